// ----- hw/rtl/telemetry_frame_keyword_parser_defines.svh -----
// ---------------------------------------------------------------------------
// Telemetry frame keyword parser: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ---------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_KEYWORD_PARSER_DEFINES_SVH
`define TELEMETRY_FRAME_KEYWORD_PARSER_DEFINES_SVH

// Same-cycle implication.
`define TFKP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TFKP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tfkp_pkg.sv -----
// ---------------------------------------------------------------------------
// Telemetry frame keyword parser package
// Kind codes, number parse phases, keyword tables and small decode helpers.
// ---------------------------------------------------------------------------
package tfkp_pkg;

  localparam int FRAME_BUFFER_SIZE_DEF = 256;
  localparam int KW_COUNT   = 5;
  localparam int KW_MAX_LEN = 5;

  localparam logic [7:0] TERM_BYTE = 8'hFF;

  // Largest magnitude kept in the accumulator (2^31).
  localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

  typedef enum logic [2:0] {
    KIND_TEMP,
    KIND_RPM,
    KIND_STATE,
    KIND_ERROR,
    KIND_FLOW,
    KIND_NONE
  } frame_kind_t;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } num_phase_t;

  // Number parser control, already qualified by the byte step.
  typedef struct packed {
    logic restart;
    logic feed;
  } num_ctl_t;

  // Keyword text, one row per kind; unused tail bytes are zero.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{8'h54, 8'h65, 8'h6D, 8'h70, 8'h00},  // Temp
    '{8'h52, 8'h70, 8'h6D, 8'h00, 8'h00},  // Rpm
    '{8'h53, 8'h74, 8'h61, 8'h74, 8'h65},  // State
    '{8'h45, 8'h72, 8'h72, 8'h6F, 8'h72},  // Error
    '{8'h46, 8'h6C, 8'h6F, 8'h77, 8'h00}   // Flow
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd3, 3'd5, 3'd5, 3'd4};

  // First still-matching keyword that is shorter than len bytes.
  function automatic frame_kind_t match_kind(input logic [KW_COUNT-1:0] flags,
                                             input logic [7:0] len);
    frame_kind_t kind;
    kind = KIND_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (flags[k] && (len > {5'd0, KW_LEN[k]})) begin
        kind = frame_kind_t'(3'(k));
      end
    end
    return kind;
  endfunction

  // Kinds that carry a decimal number.
  function automatic logic has_number(input frame_kind_t kind);
    return (kind == KIND_TEMP) || (kind == KIND_RPM) ||
           (kind == KIND_STATE) || (kind == KIND_ERROR);
  endfunction

  // Byte offset of the number within the frame.
  function automatic logic [7:0] num_offset(input frame_kind_t kind);
    logic [7:0] off;
    unique case (kind)
      KIND_TEMP:  off = 8'd6;
      KIND_RPM:   off = 8'd5;
      KIND_STATE: off = 8'd7;
      KIND_ERROR: off = 8'd7;
      default:    off = 8'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- hw/rtl/tfkp_num_parse.sv -----
// ---------------------------------------------------------------------------
// Decimal number parser
// Streams strtol-style: whitespace, optional sign, digits, saturating to 32b.
// ---------------------------------------------------------------------------
module tfkp_num_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  tfkp_pkg::num_ctl_t     num_ctl,
  input  logic [7:0]             rx_byte,
  output logic signed [31:0]     value
);

  tfkp_pkg::num_phase_t phase, phase_next;
  logic [31:0] acc, acc_next;
  logic        negative, negative_next;
  logic        overflow, overflow_next;

  logic        is_digit, is_space, is_sign;
  logic [35:0] scaled;

  assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign is_space = (rx_byte == 8'h20) || ((rx_byte >= 8'h09) && (rx_byte <= 8'h0D));
  assign is_sign  = (rx_byte == 8'h2B) || (rx_byte == 8'h2D);

  // acc * 10 + digit as shift-and-add
  assign scaled = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, rx_byte[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= tfkp_pkg::PH_SKIP;
      acc      <= '0;
      negative <= 1'b0;
      overflow <= 1'b0;
    end else begin
      phase    <= phase_next;
      acc      <= acc_next;
      negative <= negative_next;
      overflow <= overflow_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    negative_next = negative;
    overflow_next = overflow;
    priority if (num_ctl.restart) begin
      phase_next    = tfkp_pkg::PH_SKIP;
      acc_next      = '0;
      negative_next = 1'b0;
      overflow_next = 1'b0;
    end else if (num_ctl.feed) begin
      priority if (phase == tfkp_pkg::PH_SKIP && is_space) begin
        phase_next = phase;
      end else if (phase == tfkp_pkg::PH_SKIP && is_sign) begin
        negative_next = (rx_byte == 8'h2D);
        phase_next    = tfkp_pkg::PH_SIGN;
      end else if (phase == tfkp_pkg::PH_DONE) begin
        phase_next = phase;
      end else if (!is_digit) begin
        phase_next = tfkp_pkg::PH_DONE;
      end else begin
        phase_next = tfkp_pkg::PH_DIGITS;
        if (scaled > tfkp_pkg::MAG_LIMIT) begin
          overflow_next = 1'b1;
        end else begin
          acc_next = scaled[31:0];
        end
      end
    end else begin
      phase_next = phase;
    end
  end

  // Saturated signed result
  always_comb begin
    if (negative) begin
      value = overflow ? 32'sh8000_0000 : signed'(32'd0 - acc);
    end else if (overflow || acc[31]) begin
      value = 32'sh7FFF_FFFF;
    end else begin
      value = signed'(acc);
    end
  end

endmodule

// ----- hw/rtl/tfkp_frame_ctrl.sv -----
// ---------------------------------------------------------------------------
// Frame tracker
// Terminator detect, frame position, keyword matching and number gating.
// ---------------------------------------------------------------------------
module tfkp_frame_ctrl #(
  parameter int FRAME_BUFFER_SIZE = tfkp_pkg::FRAME_BUFFER_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output logic                  emit,
  output tfkp_pkg::frame_kind_t kind,
  output logic                  value_ok,
  output logic [7:0]            frame_length,
  output tfkp_pkg::num_ctl_t    num_ctl
);

  localparam logic [7:0] PosLimit = 8'(FRAME_BUFFER_SIZE - 1);
  localparam logic [7:0] KwSpan   = 8'(tfkp_pkg::KW_MAX_LEN);

  logic [15:0]                   recent;
  logic [7:0]                    pos;
  logic [tfkp_pkg::KW_COUNT-1:0] flags;

  logic                          term, wrap;
  logic [7:0]                    pos_eff, pos_inc;
  logic [tfkp_pkg::KW_COUNT-1:0] flags_eff, mismatch;
  tfkp_pkg::frame_kind_t         feed_kind;
  logic                          feed_ok;

  assign term = (rx_byte == tfkp_pkg::TERM_BYTE) && (recent == 16'hFFFF);
  // a full buffer restarts the frame before the byte is stored
  assign wrap      = !term && (pos >= PosLimit);
  assign pos_eff   = wrap ? 8'd0 : pos;
  assign flags_eff = wrap ? '1 : flags;
  assign pos_inc   = 8'(pos_eff + 8'd1);

  always_comb begin
    for (int k = 0; k < tfkp_pkg::KW_COUNT; k++) begin
      mismatch[k] = (pos_eff < KwSpan) && (pos_eff < {5'd0, tfkp_pkg::KW_LEN[k]}) &&
                    (tfkp_pkg::KW_TEXT[k][pos_eff[2:0]] != rx_byte);
    end
  end

  assign feed_kind = tfkp_pkg::match_kind(flags_eff, pos_inc);
  assign feed_ok   = (pos_eff >= KwSpan) && tfkp_pkg::has_number(feed_kind) &&
                     (pos_eff >= tfkp_pkg::num_offset(feed_kind));

  always_ff @(posedge clk) begin
    if (rst) begin
      recent <= '0;
      pos    <= '0;
      flags  <= '1;
    end else if (step) begin
      recent <= {recent[7:0], rx_byte};
      if (term) begin
        pos   <= '0;
        flags <= '1;
      end else begin
        pos   <= pos_inc;
        flags <= flags_eff & ~mismatch;
      end
    end
  end

  // end-of-frame result, from state before this byte
  assign emit         = term && (pos != 8'd0);
  assign kind         = tfkp_pkg::match_kind(flags, pos);
  assign value_ok     = tfkp_pkg::has_number(kind) && (pos > tfkp_pkg::num_offset(kind));
  assign frame_length = pos;

  assign num_ctl.restart = step && (term || wrap);
  assign num_ctl.feed    = step && !term && feed_ok;

endmodule

// ----- hw/rtl/telemetry_frame_keyword_parser.sv -----
// ---------------------------------------------------------------------------
// Telemetry frame keyword parser
// Byte stream in on s_*, one frame report out on m_* per completed frame.
// A frame ends at three 0xFF bytes in a row; the first two count in the
// frame length, the third is dropped. An empty frame reports nothing.
// The leading keyword picks the kind; a decimal at a fixed offset is parsed.
// A terminating byte passes the input register, then the result register, to m_*.
// Throughput: one byte per cycle unless a terminator waits on a held result, set
// by keyword compare and shift-add accumulate between input and result registers.
// Reset: all framing and parse state cleared, both registers empty.
// Stall: a held result keeps m_* steady; bytes that end no frame keep
// flowing past it, and a second terminator waits in the input register.
// ---------------------------------------------------------------------------
module telemetry_frame_keyword_parser #(
  parameter int FRAME_BUFFER_SIZE = tfkp_pkg::FRAME_BUFFER_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] field_value, [39:32] frame_length
  output logic [2:0]  m_tuser    // [2:0] frame_kind
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  logic                  advance;
  logic                  emit;
  tfkp_pkg::frame_kind_t kind;
  logic                  value_ok;
  logic [7:0]            frame_length;
  tfkp_pkg::num_ctl_t    num_ctl;
  logic signed [31:0]    value;

  // a byte moves on unless it would produce a request into a full, stalled slot
  assign advance  = in_valid && (!m_tvalid || m_tready || !emit);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  tfkp_frame_ctrl #(
    .FRAME_BUFFER_SIZE (FRAME_BUFFER_SIZE)
  ) u_frame_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .rx_byte      (in_byte),
    .emit         (emit),
    .kind         (kind),
    .value_ok     (value_ok),
    .frame_length (frame_length),
    .num_ctl      (num_ctl)
  );

  tfkp_num_parse u_num_parse (
    .clk     (clk),
    .rst     (rst),
    .num_ctl (num_ctl),
    .rx_byte (in_byte),
    .value   (value)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tuser <= kind;
      m_tdata <= {frame_length, value_ok ? unsigned'(value) : 32'd0};
    end
  end

endmodule

// ----- hw/rtl/tfkp_checker.sv -----
// ---------------------------------------------------------------------------
// Telemetry frame keyword parser port checker
// Watches the top level ports; bound onto every parser instance.
// ---------------------------------------------------------------------------
`include "telemetry_frame_keyword_parser_defines.svh"

module tfkp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser
);

  `TFKP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled request changed")

  `TFKP_ASSERT_IMPLY(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

  `TFKP_ASSERT_IMPLY(a_len_nonzero, m_tvalid, m_tdata[39:32] != 8'd0, "empty frame reported")

  `TFKP_ASSERT_IMPLY(a_no_value, m_tvalid && (m_tuser == tfkp_pkg::KIND_FLOW || m_tuser == tfkp_pkg::KIND_NONE), m_tdata[31:0] == 32'd0, "value on kind without number")

endmodule

bind telemetry_frame_keyword_parser tfkp_checker u_tfkp_checker (.*);
